// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MHB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHB_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/mhb_pkg.sv
// ----------------------------------------------------------------------------
// mhb_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mhb_pkg;

    localparam int MHB_ANGLE_FRAC_BITS = 16;
    localparam int MHB_CORDIC_STAGES   = 18;

    // Turn conversion: turns = A * 2^32 / 17280 rounded, split as
    // A * TURN_Q + floor((A * TURN_R + TURN_BIAS) / DIV_K).
    localparam int TURN_Q    = 248551;
    localparam int TURN_R    = 47;
    localparam int TURN_BIAS = 67;
    localparam int DIV_K     = 135;
    localparam int RECIP_M   = 1988410;
    localparam int RECIP_SH  = 28;

    typedef struct packed {
        logic        bad;
        logic [14:0] a_lat;
        logic [14:0] a_lon;
    } t_loc_code;

    function automatic logic [7:0] mhb_letter_off(input logic [7:0] ch);
        logic [7:0] up;
        up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
        return up - 8'h41;
    endfunction

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/mhb_sincos.sv
// ----------------------------------------------------------------------------
// mhb_sincos
// Pipelined rotation CORDIC: sine and cosine of a 32-bit binary-turn angle.
// ----------------------------------------------------------------------------
module mhb_sincos
    import mhb_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = MHB_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = MHB_CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_ang,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_sin,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_cos
);

    localparam int W  = ANGLE_FRAC_BITS + 3;
    localparam int ZW = 34;
    localparam int N  = CORDIC_STAGES;
    localparam logic [63:0] GAIN_FULL =
        ((64'h9B74EDA8 << ANGLE_FRAC_BITS) + 64'h80000000) >> 32;
    localparam logic signed [W-1:0] X_START = W'(GAIN_FULL);

    logic signed [W-1:0]  r_x [N+1];
    logic signed [W-1:0]  r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    logic                 r_flip [N+1];

    logic [31:0]          n_shift;
    logic                 n_flip;
    logic [31:0]          n_a;

    // Angles in the left half-plane are turned by half a turn and the
    // result negated, so the iterations only see -90..90 degrees.
    always_comb begin
        n_shift = i_ang + 32'h40000000;
        n_flip  = n_shift[31];
        n_a     = n_flip ? i_ang - 32'h80000000 : i_ang;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= X_START;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'(signed'(n_a));
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [W-1:0]  n_dx;
        logic signed [W-1:0]  n_dy;
        logic signed [ZW-1:0] n_step;
        assign n_dx   = r_x[i] >>> i;
        assign n_dy   = r_y[i] >>> i;
        assign n_step = ZW'(atan_turn(5'(i)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - n_dy;
                    r_y[i+1] <= r_y[i] + n_dx;
                    r_z[i+1] <= r_z[i] - n_step;
                end else begin
                    r_x[i+1] <= r_x[i] + n_dy;
                    r_y[i+1] <= r_y[i] - n_dx;
                    r_z[i+1] <= r_z[i] + n_step;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    assign o_sin = r_flip[N] ? -r_y[N] : r_y[N];
    assign o_cos = r_flip[N] ? -r_x[N] : r_x[N];

endmodule

// File: rtl/mhb_vector.sv
// ----------------------------------------------------------------------------
// mhb_vector
// Pipelined vectoring CORDIC: atan2(y, x) as a 32-bit binary-turn angle.
// ----------------------------------------------------------------------------
module mhb_vector
    import mhb_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = MHB_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = MHB_CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ANGLE_FRAC_BITS+4:0] i_y,
    input  logic signed [ANGLE_FRAC_BITS+4:0] i_x,
    output logic [31:0]                       o_ang
);

    localparam int XW = ANGLE_FRAC_BITS + 5;
    localparam int N  = CORDIC_STAGES;

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic [31:0]          r_z [N+1];
    logic                 r_zero [N+1];

    logic                 n_neg;

    assign n_neg = i_x[XW-1];

    // A vector in the left half-plane is mirrored through the origin and
    // starts half a turn on.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_neg ? -i_x : i_x;
            r_y[0]    <= n_neg ? -i_y : i_y;
            r_z[0]    <= n_neg ? 32'h80000000 : 32'h0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [XW-1:0] n_dx;
        logic signed [XW-1:0] n_dy;
        logic [31:0]          n_step;
        assign n_dx   = r_x[i] >>> i;
        assign n_dy   = r_y[i] >>> i;
        assign n_step = atan_turn(5'(i));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] - n_dy;
                    r_y[i+1] <= r_y[i] + n_dx;
                    r_z[i+1] <= r_z[i] - n_step;
                end else begin
                    r_x[i+1] <= r_x[i] + n_dy;
                    r_y[i+1] <= r_y[i] - n_dx;
                    r_z[i+1] <= r_z[i] + n_step;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_ang = r_zero[N] ? 32'h0 : r_z[N];

endmodule

// File: rtl/maidenhead_bearing_unit.sv
// ----------------------------------------------------------------------------
// maidenhead_bearing_unit
// Great-circle bearing between two Maidenhead locators, plus rotor offset.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry two packed ASCII locators with their
// length flags; a transfer happens when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry the azimuth in whole degrees and a
// flag for a malformed locator (azimuth then reads 0).
// One item is taken every cycle while o_stall is low. An item passes
// 2*CORDIC_STAGES+11 register stages, the first loaded at its transfer edge:
// four stages of locator decode and angle conversion, two CORDIC pipelines
// of CORDIC_STAGES+1 stages each, three stages of products and two of degree
// conversion and wrapping.
// The whole pipeline advances as one; while a result sits in the output
// register and the receiver stalls, every stage holds and o_stall is raised.
// Reset clears all valid bits and sets the rotor offset to zero. The offset
// is written through i_cfg_we / i_cfg_data; the user must do so only while
// no item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module maidenhead_bearing_unit
    import mhb_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = MHB_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = MHB_CORDIC_STAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_home_locator,
    input  logic        i_home_is_long,
    input  logic [47:0] i_far_locator,
    input  logic        i_far_is_long,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_azimuth_deg,
    output logic        o_bad_locator
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int N     = CORDIC_STAGES;
    localparam int W     = F + 3;
    localparam int W1    = W + 1;
    localparam int XW    = F + 5;
    localparam int DEPTH = 2 * N + 11;
    localparam int LAST  = DEPTH - 1;

    function automatic t_loc_code decode_loc(input logic [47:0] loc, input logic is_long);
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] d3;
        logic [7:0] d4;
        logic [7:0] s5;
        logic [7:0] s6;
        t_loc_code  res;
        f1 = mhb_letter_off(loc[47:40]);
        f2 = mhb_letter_off(loc[39:32]);
        d3 = loc[31:24] - 8'h30;
        d4 = loc[23:16] - 8'h30;
        s5 = mhb_letter_off(loc[15:8]);
        s6 = mhb_letter_off(loc[7:0]);
        res.bad = (f1 > 8'd17) || (f2 > 8'd17) || (d3 > 8'd9) || (d4 > 8'd9) ||
                  (is_long && ((s5 > 8'd23) || (s6 > 8'd23)));
        // Coordinates are offset by a full turn (17280 units of 1/48 degree).
        res.a_lat = 15'(f2) * 15'd480 + 15'(d4) * 15'd48 + 15'd12960 +
                    (is_long ? 15'(s6) * 15'd2 + 15'd1 : 15'd0);
        res.a_lon = 15'(f1) * 15'd960 + 15'(d3) * 15'd96 + 15'd8640 +
                    (is_long ? 15'(s5) * 15'd4 + 15'd2 : 15'd0);
        return res;
    endfunction

    logic                w_en;
    logic [DEPTH-1:0]    r_vld;
    logic [DEPTH-1:0]    r_bad;
    logic signed [9:0]   r_rotor_offset;

    t_loc_code           n_home;
    t_loc_code           n_far;
    logic                n_bad;

    // Channel order: home latitude, far latitude, home longitude, far longitude.
    logic [14:0]         r_a    [4];
    logic [31:0]         r_p    [4];
    logic [20:0]         r_n    [4];
    logic [13:0]         r_q0   [4];
    logic [31:0]         r_p2   [4];
    logic [20:0]         r_n2   [4];
    logic [31:0]         r_turn [4];
    logic [31:0]         n_p    [4];
    logic [20:0]         n_n    [4];
    logic [13:0]         n_q0   [4];
    logic [20:0]         n_rem  [4];
    logic [31:0]         n_turn [4];
    logic [31:0]         n_dlon;

    logic signed [W-1:0]   w_s1, w_c1, w_s2, w_c2, w_sd, w_cd;
    logic signed [2*W-1:0] r_m_sdc2, r_m_c1s2, r_m_s1c2;
    logic signed [W-1:0]   r_cd;
    logic signed [W-1:0]   r_arg1, r_c1s2, n_s1c2;
    logic signed [2*W-1:0] r_t;
    logic signed [W-1:0]   r_arg1b;
    logic signed [W1-1:0]  r_arg2;
    logic [31:0]           w_bear;
    logic [8:0]            n_deg;
    logic [8:0]            r_deg;
    logic signed [11:0]    n_sum;
    logic signed [11:0]    n_wrap;
    logic [8:0]            r_az;

    assign w_en          = !r_vld[LAST] || !i_stall;
    assign o_stall       = !w_en;
    assign o_valid       = r_vld[LAST];
    assign o_azimuth_deg = r_az;
    assign o_bad_locator = r_bad[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor_offset <= '0;
        end else if (i_cfg_we) begin
            r_rotor_offset <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bad <= {r_bad[LAST-1:0], n_bad};
        end
    end

    always_comb begin
        n_home = decode_loc(i_home_locator, i_home_is_long);
        n_far  = decode_loc(i_far_locator, i_far_is_long);
        n_bad  = n_home.bad || n_far.bad;
    end

    // Division by 17280 is a multiply by 2^25/135 plus a reciprocal
    // estimate of the small remainder term, corrected by one compare.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_p[j]   = 32'(33'(r_a[j]) * 33'(TURN_Q));
            n_n[j]   = 21'(r_a[j]) * 21'(TURN_R) + 21'(TURN_BIAS);
            n_q0[j]  = 14'((42'(r_n[j]) * 42'(RECIP_M)) >> RECIP_SH);
            n_rem[j] = r_n2[j] - 21'(r_q0[j]) * 21'(DIV_K);
            n_turn[j] = r_p2[j] + 32'(r_q0[j]) +
                        ((n_rem[j] >= 21'(DIV_K)) ? 32'd1 : 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a[0] <= n_home.a_lat;
            r_a[1] <= n_far.a_lat;
            r_a[2] <= n_home.a_lon;
            r_a[3] <= n_far.a_lon;
            for (int j = 0; j < 4; j++) begin
                r_p[j]    <= n_p[j];
                r_n[j]    <= n_n[j];
                r_q0[j]   <= n_q0[j];
                r_p2[j]   <= r_p[j];
                r_n2[j]   <= r_n[j];
                r_turn[j] <= n_turn[j];
            end
        end
    end

    assign n_dlon = r_turn[3] - r_turn[2];

    mhb_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(N)) u_sc_lat1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_turn[0]),
        .o_sin (w_s1),
        .o_cos (w_c1)
    );

    mhb_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(N)) u_sc_lat2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_turn[1]),
        .o_sin (w_s2),
        .o_cos (w_c2)
    );

    mhb_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(N)) u_sc_dlon (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (n_dlon),
        .o_sin (w_sd),
        .o_cos (w_cd)
    );

    assign n_s1c2 = W'(r_m_s1c2 >>> F);

    // y = sin(dlon) cos(lat2); x = cos(lat1) sin(lat2) - sin(lat1) cos(lat2) cos(dlon)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_sdc2 <= w_sd * w_c2;
            r_m_c1s2 <= w_c1 * w_s2;
            r_m_s1c2 <= w_s1 * w_c2;
            r_cd     <= w_cd;
            r_arg1   <= W'(r_m_sdc2 >>> F);
            r_c1s2   <= W'(r_m_c1s2 >>> F);
            r_t      <= n_s1c2 * r_cd;
            r_arg1b  <= r_arg1;
            r_arg2   <= W1'(r_c1s2) - W1'(r_t >>> F);
        end
    end

    mhb_vector #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(N)) u_vec (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (XW'(r_arg1b)),
        .i_x   (XW'(r_arg2)),
        .o_ang (w_bear)
    );

    always_comb begin
        n_deg  = 9'((41'(w_bear) * 41'd360 + 41'h80000000) >> 32);
        n_sum  = 12'(r_deg) + 12'(r_rotor_offset);
        n_wrap = n_sum;
        if (n_wrap < 0) begin
            n_wrap = n_wrap + 12'sd360;
        end
        if (n_wrap < 0) begin
            n_wrap = n_wrap + 12'sd360;
        end
        if (n_wrap >= 12'sd360) begin
            n_wrap = n_wrap - 12'sd360;
        end
        if (n_wrap >= 12'sd360) begin
            n_wrap = n_wrap - 12'sd360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg <= n_deg;
            r_az  <= r_bad[LAST-1] ? 9'd0 : n_wrap[8:0];
        end
    end

    `MHB_ASSERT(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_locator |-> o_azimuth_deg == 9'd0, "bad locator with nonzero azimuth")
    `MHB_ASSERT(a_az_range, i_clk, i_rst_n, o_valid |-> o_azimuth_deg < 9'd360, "azimuth out of range")
    `MHB_ASSERT(a_hold, i_clk, i_rst_n, !w_en |=> $stable(r_vld), "pipeline moved while held")
    `MHB_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled without a held result")

endmodule
